// ===== hdl/nt_pkg.sv =====
// shared types and codes for the name table
package nt_pkg;

  // request actions
  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_LIST   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_ABSENT    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;
  localparam logic [2:0] ST_LISTED    = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key_name;
  } nt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_name;
    logic [3:0]  entry_index;
    logic [4:0]  entry_count;
    logic        last_result;
  } nt_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRD,
    S_DWR,
    S_LIST,
    S_EMIT
  } nt_state_t;

endpackage

// ===== hdl/nt_mem.sv =====
// key store: one write port, one registered read port
module nt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);

  logic [63:0] mem [DEPTH];

  // write and registered read; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/nt_out.sv =====
// result output register between the controller and the result channel
module nt_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  nt_pkg::nt_out_t up_data,
  output logic            out_valid,
  input  logic            out_ready,
  output nt_pkg::nt_out_t out_data
);

  logic            vld_r;
  logic            vld_nxt;
  nt_pkg::nt_out_t data_r;

  assign up_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  // hold flag
  always_comb begin
    vld_nxt = vld_r;
    if (up_ready) begin
      vld_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload load
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= up_data;
    end
  end

endmodule

// ===== hdl/nt_ctrl.sv =====
// request sequencer: scans, appends, swap-deletes and lists through the key store
module nt_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nt_pkg::nt_in_t  in_data,
  output logic            res_valid,
  input  logic            res_ready,
  output nt_pkg::nt_out_t res_data,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  logic [63:0]     rd_data,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [63:0]     wr_data
);

  nt_pkg::nt_state_t state_r, state_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              q_vld_r, q_vld_nxt;
  logic [AW-1:0]     q_idx_r, q_idx_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  nt_pkg::nt_out_t   res_r, res_nxt;

  logic              accept;
  logic              hit;
  logic              scan_done;
  logic              issue;
  logic              is_full;
  logic [CW-1:0]     last_idx;
  logic              list_last;

  assign accept    = in_valid && in_ready;
  assign last_idx  = count_r - CW'(1);
  assign is_full   = (count_r == CW'(CAPACITY));
  assign hit       = q_vld_r && (rd_data == key_r);
  assign scan_done = hit || (!q_vld_r && (rd_idx_r == count_r));
  assign list_last = (CW'(q_idx_r) == last_idx);

  // read issue: scan stops on a hit, list stops while the result is stalled
  always_comb begin
    issue = 1'b0;
    case (state_r)
      nt_pkg::S_SCAN: issue = (rd_idx_r < count_r) && !hit;
      nt_pkg::S_LIST: issue = (rd_idx_r < count_r) && (!q_vld_r || res_ready);
      default:        issue = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.action == nt_pkg::ACT_LIST) begin
            state_nxt = (count_r == '0) ? nt_pkg::S_EMIT : nt_pkg::S_LIST;
          end else begin
            state_nxt = nt_pkg::S_SCAN;
          end
        end
      end
      nt_pkg::S_SCAN: begin
        if (scan_done) begin
          if (hit && (act_r == nt_pkg::ACT_DELETE)) begin
            state_nxt = nt_pkg::S_DRD;
          end else begin
            state_nxt = nt_pkg::S_EMIT;
          end
        end
      end
      nt_pkg::S_DRD: state_nxt = nt_pkg::S_DWR;
      nt_pkg::S_DWR: state_nxt = nt_pkg::S_EMIT;
      nt_pkg::S_LIST: begin
        if (q_vld_r && res_ready && list_last) begin
          state_nxt = nt_pkg::S_IDLE;
        end
      end
      nt_pkg::S_EMIT: begin
        if (res_ready) begin
          state_nxt = nt_pkg::S_IDLE;
        end
      end
      default: state_nxt = nt_pkg::S_IDLE;
    endcase
  end

  // outputs: handshakes, memory port and result payload
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_data  = res_r;
    rd_en     = issue;
    rd_addr   = rd_idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = hit_idx_r;
    wr_data   = rd_data;
    case (state_r)
      nt_pkg::S_IDLE: in_ready = 1'b1;
      nt_pkg::S_SCAN: begin
        // append on a create that missed with room left
        if (scan_done && !hit && (act_r == nt_pkg::ACT_CREATE) && !is_full) begin
          wr_en   = 1'b1;
          wr_addr = count_r[AW-1:0];
          wr_data = key_r;
        end
      end
      nt_pkg::S_DRD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx[AW-1:0];
      end
      nt_pkg::S_DWR: wr_en = 1'b1;
      nt_pkg::S_LIST: begin
        res_valid            = q_vld_r;
        res_data.status      = nt_pkg::ST_LISTED;
        res_data.entry_name  = rd_data;
        res_data.entry_index = 4'(q_idx_r);
        res_data.entry_count = 5'(count_r);
        res_data.last_result = list_last;
      end
      nt_pkg::S_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    act_nxt     = act_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    q_idx_nxt   = q_idx_r;
    hit_idx_nxt = hit_idx_r;
    res_nxt     = res_r;
    q_vld_nxt   = issue || ((state_r == nt_pkg::S_LIST) && q_vld_r && !res_ready);
    if (issue) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
      q_idx_nxt  = rd_idx_r[AW-1:0];
    end
    case (state_r)
      nt_pkg::S_IDLE: begin
        rd_idx_nxt = '0;
        q_vld_nxt  = 1'b0;
        if (accept) begin
          act_nxt = in_data.action;
          key_nxt = in_data.key_name;
          res_nxt = '{status: nt_pkg::ST_EMPTY, entry_name: '0, entry_index: '0,
                      entry_count: 5'(count_r), last_result: 1'b1};
        end
      end
      nt_pkg::S_SCAN: begin
        if (scan_done) begin
          res_nxt.last_result = 1'b1;
          res_nxt.entry_name  = '0;
          res_nxt.entry_index = '0;
          res_nxt.entry_count = 5'(count_r);
          hit_idx_nxt         = q_idx_r;
          if (act_r == nt_pkg::ACT_CREATE) begin
            if (hit) begin
              res_nxt.status      = nt_pkg::ST_DUPLICATE;
              res_nxt.entry_name  = key_r;
              res_nxt.entry_index = 4'(q_idx_r);
            end else if (is_full) begin
              res_nxt.status = nt_pkg::ST_FULL;
            end else begin
              count_nxt           = count_r + CW'(1);
              res_nxt.status      = nt_pkg::ST_CREATED;
              res_nxt.entry_name  = key_r;
              res_nxt.entry_index = 4'(count_r);
              res_nxt.entry_count = 5'(count_r + CW'(1));
            end
          end else if (count_r == '0) begin
            res_nxt.status = nt_pkg::ST_EMPTY;
          end else if (!hit) begin
            res_nxt.status = nt_pkg::ST_ABSENT;
          end else begin
            res_nxt.status      = (act_r == nt_pkg::ACT_DELETE) ?
                                  nt_pkg::ST_DELETED : nt_pkg::ST_FOUND;
            res_nxt.entry_name  = key_r;
            res_nxt.entry_index = 4'(q_idx_r);
          end
        end
      end
      nt_pkg::S_DWR: begin
        // last entry moved into the freed slot, table shrinks by one
        count_nxt           = last_idx;
        res_nxt.entry_count = 5'(last_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nt_pkg::S_IDLE;
      count_r <= '0;
      q_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      q_vld_r <= q_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    q_idx_r   <= q_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r     <= res_nxt;
  end

  // count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // every store write changes the count on the next cycle
  a_write_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r != $past(count_r)))
    else $error("store written without count update");

  // listed entries are always stored slots
  a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nt_pkg::S_LIST && q_vld_r) |-> (CW'(q_idx_r) < count_r))
    else $error("listed slot beyond count");

  // no new request is taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("request accepted while result pending");

endmodule

// ===== hdl/name_table_insert_delete_search.sv =====
// top level of the name table: up to CAPACITY unique 64-bit keys with swap delete
//
// Requests enter on in_valid/in_ready with in_data (action, key_name); results
// leave on out_valid/out_ready with out_data (status, entry_name, entry_index,
// entry_count, last_result). One request is worked at a time; in_ready is high
// only while the sequencer is idle.
// Create, delete and search scan the key store one slot per cycle through its
// single registered read port. A delete that hits then reads the last key and
// writes it into the freed slot. List issues one read per cycle and hands over
// one result per cycle while the output register takes them. in_ready comes
// back in the cycle after the last result of a request is handed over. Each
// request gives one result, list gives one per stored key with last_result on
// the final one (or one empty status). Results show on out_valid in the cycle
// after they are handed over, through an output register; a stalled out_ready
// holds that register and pauses the sequencer, no result is dropped.
// Synchronous active-low reset empties the table (count to zero) and clears the
// handshakes; store contents are not cleared since only slots below the count
// are read.
module name_table_insert_delete_search #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nt_pkg::nt_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output nt_pkg::nt_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic            res_valid;
  logic            res_ready;
  nt_pkg::nt_out_t res_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [63:0]     rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [63:0]     wr_data;

  // sequencer
  nt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // key store
  nt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // result register
  nt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (res_valid),
    .up_ready  (res_ready),
    .up_data   (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
